### hdl/mvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvp_pkg: shared types and helpers for the MAVLink v1 frame parser
// Phase encoding, CSR table layout, result beat layout and the CRC byte step.
// ----------------------------------------------------------------------------
package mvp_pkg;

   localparam int unsigned TableEntries = 4;
   localparam int unsigned CsrIndexWidth = 4;

   localparam logic [7:0]  START_BYTE = 8'hFE;
   localparam logic [15:0] CRC_SEED   = 16'hFFFF;

   // CSR register map
   localparam logic [CsrIndexWidth-1:0] CSR_TABLE_ID_0 = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TABLE_ID_1 = 4'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_TABLE_ID_2 = 4'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_TABLE_ID_3 = 4'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_EXTRA_0    = 4'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_EXTRA_1    = 4'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_EXTRA_2    = 4'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_EXTRA_3    = 4'd7;

   localparam logic [7:0] RST_TABLE_ID_0 = 8'd2;
   localparam logic [7:0] RST_TABLE_ID_1 = 8'd24;
   localparam logic [7:0] RST_TABLE_ID_2 = 8'd33;
   localparam logic [7:0] RST_TABLE_ID_3 = 8'd74;
   localparam logic [7:0] RST_EXTRA_0    = 8'd137;
   localparam logic [7:0] RST_EXTRA_1    = 8'd24;
   localparam logic [7:0] RST_EXTRA_2    = 8'd104;
   localparam logic [7:0] RST_EXTRA_3    = 8'd20;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_LEN     = 4'd1,
      PH_SEQ     = 4'd2,
      PH_SYS     = 4'd3,
      PH_COMP    = 4'd4,
      PH_MSGID   = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CRC1    = 4'd7,
      PH_CRC2    = 4'd8
   } phase_type;

   typedef struct packed {
      logic [TableEntries-1:0][7:0] ids;
      logic [TableEntries-1:0][7:0] extras;
   } extra_table_type;

   typedef struct packed {
      logic       is_payload;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_end;
      logic       crc_ok;
      logic [7:0] frame_msg_id;
      logic [7:0] frame_len;
      logic       id_known;
   } result_type;

   typedef struct packed {
      logic       known;
      logic [7:0] extra;
   } lookup_type;

   // CRC-16/MCRF4XX, one byte
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
             ^ {12'h000, t[7:4]};
   endfunction

   // lowest-numbered matching entry wins; no match gives extra 0
   function automatic lookup_type extra_lookup(input logic [7:0] id,
                                               input extra_table_type tbl);
      lookup_type r;
      r.known = 1'b0;
      r.extra = 8'h00;
      for (int i = TableEntries - 1; i >= 0; i--) begin
         if (tbl.ids[i] == id) begin
            r.known = 1'b1;
            r.extra = tbl.extras[i];
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/mvp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvp_parse_core: frame state machine and running checksum
// Takes one byte per accept strobe, updates the frame state and produces the
// result beat for that byte combinationally.
// ----------------------------------------------------------------------------
module mvp_parse_core
   import mvp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      rx_byte,
   input  wire extra_table_type tbl,
   output result_type           result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  declared_len_ff, declared_len_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  current_id_ff, current_id_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_byte;
   lookup_type  lk;

   assign byte_count_in = (phase_ff == PH_PAYLOAD) ? byte_count_ff + 8'd1 : 8'd0;
   assign current_id_in = (phase_ff == PH_MSGID) ? rx_byte : current_id_ff;
   assign declared_len_in = (phase_ff == PH_LEN) ? rx_byte : declared_len_ff;
   assign lk = extra_lookup(current_id_in, tbl);
   assign crc_byte = crc_step((phase_ff == PH_LEN) ? CRC_SEED : crc_ff, rx_byte);

   // next phase
   always_comb begin
      case (phase_ff)
         PH_IDLE:    phase_in = (rx_byte == START_BYTE) ? PH_LEN : PH_IDLE;
         PH_LEN:     phase_in = PH_SEQ;
         PH_SEQ:     phase_in = PH_SYS;
         PH_SYS:     phase_in = PH_COMP;
         PH_COMP:    phase_in = PH_MSGID;
         PH_MSGID:   phase_in = (declared_len_ff != 8'd0) ? PH_PAYLOAD : PH_CRC1;
         PH_PAYLOAD: phase_in = (byte_count_in >= declared_len_ff) ? PH_CRC1 : PH_PAYLOAD;
         PH_CRC1:    phase_in = PH_CRC2;
         PH_CRC2:    phase_in = PH_IDLE;
         default:    phase_in = PH_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      result     = '0;
      case (phase_ff)
         PH_LEN, PH_SEQ, PH_SYS, PH_COMP: begin
            crc_in = crc_byte;
         end
         PH_MSGID: begin
            crc_in = (declared_len_ff != 8'd0) ? crc_byte : crc_step(crc_byte, lk.extra);
         end
         PH_PAYLOAD: begin
            result.is_payload    = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = byte_count_ff;
            crc_in = (byte_count_in >= declared_len_ff) ? crc_step(crc_byte, lk.extra)
                                                        : crc_byte;
         end
         PH_CRC1: begin
            crc_low_in = rx_byte;
         end
         PH_CRC2: begin
            result.frame_end = 1'b1;
            result.crc_ok    = ({rx_byte, crc_low_ff} == crc_ff);
         end
         default: begin
         end
      endcase
      result.frame_msg_id = current_id_in;
      result.frame_len    = declared_len_in;
      result.id_known     = lk.known;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         declared_len_ff <= 8'd0;
         byte_count_ff   <= 8'd0;
         current_id_ff   <= 8'd0;
         crc_low_ff      <= 8'd0;
         crc_ff          <= CRC_SEED;
      end else if (accept) begin
         phase_ff        <= phase_in;
         declared_len_ff <= declared_len_in;
         byte_count_ff   <= byte_count_in;
         current_id_ff   <= current_id_in;
         crc_low_ff      <= crc_low_in;
         crc_ff          <= crc_in;
      end
   end

endmodule
`default_nettype wire

### hdl/mavlink_v1_frame_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavlink_v1_frame_parser_top: MAVLink v1 byte-stream frame parser
// Hunts for frames, passes payload bytes out with their index and reports
// the CRC-16/MCRF4XX verdict (with per-id extra byte) on the last byte.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  req      in         req_valid/req_stall  req_rx_byte
//  rsp      out        rsp_valid/rsp_stall  rsp_is_payload .. rsp_id_known
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
//  Every input beat yields exactly one registered result beat.
//  Sustained rate is one beat per cycle while rsp_stall is low; the frame
//  state and checksum update is a single combinational step in mvp_parse_core.
//  Output register plus one skid entry: input keeps flowing while a result
//  waits; req_stall rises only when the skid entry is occupied.
//  Synchronous active-high reset clears frame state, valids and loads the
//  default extra-byte table. csr_ready is always high.
//
// ----------------------------------------------------------------------------
module mavlink_v1_frame_parser_top
   import mvp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [7:0]               req_rx_byte,

   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_is_payload,
   output      logic [7:0]               rsp_payload_byte,
   output      logic [7:0]               rsp_payload_index,
   output      logic                     rsp_frame_end,
   output      logic                     rsp_crc_ok,
   output      logic [7:0]               rsp_frame_msg_id,
   output      logic [7:0]               rsp_frame_len,
   output      logic                     rsp_id_known,

   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [7:0]               csr_wdata
);

   extra_table_type tbl_ff;
   result_type      core_result;
   result_type      out_ff;
   result_type      skid_ff;
   logic            out_valid_ff;
   logic            skid_valid_ff;
   logic            req_take;
   logic            out_take;

   // ---- CSR table --------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_ff.ids    <= {RST_TABLE_ID_3, RST_TABLE_ID_2, RST_TABLE_ID_1, RST_TABLE_ID_0};
         tbl_ff.extras <= {RST_EXTRA_3, RST_EXTRA_2, RST_EXTRA_1, RST_EXTRA_0};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TABLE_ID_0: tbl_ff.ids[0]    <= csr_wdata;
            CSR_TABLE_ID_1: tbl_ff.ids[1]    <= csr_wdata;
            CSR_TABLE_ID_2: tbl_ff.ids[2]    <= csr_wdata;
            CSR_TABLE_ID_3: tbl_ff.ids[3]    <= csr_wdata;
            CSR_EXTRA_0:    tbl_ff.extras[0] <= csr_wdata;
            CSR_EXTRA_1:    tbl_ff.extras[1] <= csr_wdata;
            CSR_EXTRA_2:    tbl_ff.extras[2] <= csr_wdata;
            CSR_EXTRA_3:    tbl_ff.extras[3] <= csr_wdata;
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // ---- parser -----------------------------------------------------------
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   mvp_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_take),
      .rx_byte (req_rx_byte),
      .tbl     (tbl_ff),
      .result  (core_result)
   );

   // ---- output register + skid entry -------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no new beat can enter while the skid entry is full
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (out_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (req_take) begin
         if (out_valid_ff && !out_take) begin
            skid_ff <= core_result;
         end else begin
            out_ff <= core_result;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_payload    = out_ff.is_payload;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_index = out_ff.payload_index;
   assign rsp_frame_end     = out_ff.frame_end;
   assign rsp_crc_ok        = out_ff.crc_ok;
   assign rsp_frame_msg_id  = out_ff.frame_msg_id;
   assign rsp_frame_len     = out_ff.frame_len;
   assign rsp_id_known      = out_ff.id_known;

endmodule
`default_nettype wire
